>>> design/telnet_option_responder_macros.svh
// assertion macros shared by the telnet option responder modules
// expects clk and rst to be visible in the module that uses them
`ifndef TELNET_OPTION_RESPONDER_MACROS_SVH
`define TELNET_OPTION_RESPONDER_MACROS_SVH

// property that must hold on every clock edge outside reset
`define TOR_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// implication checked on the same edge
`define TOR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

>>> design/tor_pkg.sv
// shared types and telnet code points for the option responder
// no dependencies
`timescale 1ns / 1ps

package tor_pkg;

  localparam logic [7:0] CODE_IAC  = 8'd255;
  localparam logic [7:0] CODE_DONT = 8'd254;
  localparam logic [7:0] CODE_DO   = 8'd253;
  localparam logic [7:0] CODE_WONT = 8'd252;
  localparam logic [7:0] CODE_WILL = 8'd251;
  localparam logic [7:0] CODE_SB   = 8'd250;
  localparam logic [7:0] CODE_SE   = 8'd240;
  localparam logic [7:0] OPT_ECHO  = 8'd1;
  localparam logic [7:0] OPT_SGA   = 8'd3;

  // one pending reply: verb and option, the leading iac is implied
  typedef struct packed {
    logic [7:0] verb;
    logic [7:0] option;
  } reply_req_t;

endpackage

>>> design/telnet_option_responder.sv
// telnet option responder: one received byte per cycle unless an option byte
// finds the queue full; replies iac/verb/option. An accepted option byte is
// queued, then its iac is registered; replies drain one word per cycle while
// m_tready is high; a queue between parser and serializer absorbs output stalls
// reset (rst, synchronous, active high) returns the parser to idle and empties all
`timescale 1ns / 1ps

module telnet_option_responder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  // received stream
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] rx_byte
  // reply stream
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] reply_byte
  output logic       m_tlast    // reply_last, set on the option word
);
  import tor_pkg::*;

  // front to queue
  logic       q_full;
  logic       q_push;
  reply_req_t push_req;

  // queue to back
  logic       q_pop;
  logic       q_valid;
  reply_req_t pop_req;

  // parser: tracks iac, will/do, subnegotiation; only stalls on an option
  // word when the queue has no room, plain data and commands always pass
  tor_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_req    (push_req)
  );

  // holds decided replies so a slow reply sink does not back up parsing
  tor_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_req  (push_req),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_req   (pop_req)
  );

  // serializer: registered output, iac then verb then option with tlast
  tor_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_req    (pop_req),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

>>> design/tor_front.sv
// front end: parses the received byte stream and queues reply requests
// depends on tor_pkg
`timescale 1ns / 1ps

module tor_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,   // [7:0] rx_byte
  input  logic              q_full,
  output logic              q_push,
  output tor_pkg::reply_req_t q_req
);
  import tor_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_IAC  = 3'd1,
    PH_WILL = 3'd2,
    PH_DO   = 3'd3,
    PH_SUB  = 3'd4
  } phase_t;

  phase_t phase;
  logic   wants_reply;
  logic   accept;

  // only an option byte needs room in the queue
  assign wants_reply = (phase == PH_WILL) || (phase == PH_DO);
  assign s_tready    = !(wants_reply && q_full);
  assign accept      = s_tvalid && s_tready;
  assign q_push      = accept && wants_reply;

  always_comb begin
    q_req.option = s_tdata;
    if (phase == PH_WILL) begin
      q_req.verb = (s_tdata == OPT_SGA) ? CODE_DO : CODE_DONT;
    end else begin
      q_req.verb = (s_tdata == OPT_SGA) ? CODE_WILL : CODE_WONT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else if (accept) begin
      case (phase)
        PH_IAC: begin
          if (s_tdata == CODE_WILL) begin
            phase <= PH_WILL;
          end else if (s_tdata == CODE_DO) begin
            phase <= PH_DO;
          end else if (s_tdata == CODE_SB) begin
            phase <= PH_SUB;
          end else begin
            phase <= PH_IDLE;
          end
        end
        PH_WILL, PH_DO: begin
          phase <= PH_IDLE;
        end
        PH_SUB: begin
          if (s_tdata == CODE_SE) begin
            phase <= PH_IDLE;
          end
        end
        default: begin
          phase <= (s_tdata == CODE_IAC) ? PH_IAC : PH_IDLE;
        end
      endcase
    end
  end

endmodule

>>> design/tor_queue.sv
// short first-in first-out queue of reply requests between front and back
// depends on tor_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "telnet_option_responder_macros.svh"

module tor_queue #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  tor_pkg::reply_req_t push_req,
  output logic                full,
  input  logic                pop,
  output logic                pop_valid,
  output tor_pkg::reply_req_t pop_req
);
  import tor_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  reply_req_t    entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full      = (count == CW'(DEPTH));
  assign pop_valid = (count != '0);
  assign pop_req   = entries[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  `TOR_ASSERT(a_count_bound, count <= CW'(DEPTH), "queue count above depth")
  `TOR_ASSERT(a_no_push_full, !(push && full), "push into a full queue")
  `TOR_ASSERT_IMPL(a_pop_nonempty, pop, pop_valid, "pop from an empty queue")

endmodule

>>> design/tor_back.sv
// back end: turns each queued request into three reply words
// depends on tor_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "telnet_option_responder_macros.svh"

module tor_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  tor_pkg::reply_req_t q_req,
  output logic                q_pop,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [7:0]          m_tdata,   // [7:0] reply_byte
  output logic                m_tlast    // reply_last
);
  import tor_pkg::*;

  typedef enum logic [1:0] {
    B_NONE = 2'd0,
    B_VERB = 2'd1,
    B_OPT  = 2'd2
  } pend_t;

  pend_t      pend;
  reply_req_t cur;
  logic       load;

  // output register is free or is being taken this cycle
  assign load  = !m_tvalid || m_tready;
  assign q_pop = load && (pend == B_NONE) && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend     <= B_NONE;
      m_tvalid <= 1'b0;
      m_tlast  <= 1'b0;
    end else if (load) begin
      case (pend)
        B_VERB: begin
          m_tvalid <= 1'b1;
          m_tdata  <= cur.verb;
          m_tlast  <= 1'b0;
          pend     <= B_OPT;
        end
        B_OPT: begin
          m_tvalid <= 1'b1;
          m_tdata  <= cur.option;
          m_tlast  <= 1'b1;
          pend     <= B_NONE;
        end
        default: begin
          if (q_valid) begin
            cur      <= q_req;
            m_tvalid <= 1'b1;
            m_tdata  <= CODE_IAC;
            m_tlast  <= 1'b0;
            pend     <= B_VERB;
          end else begin
            m_tvalid <= 1'b0;
            m_tlast  <= 1'b0;
            pend     <= B_NONE;
          end
        end
      endcase
    end
  end

  `TOR_ASSERT_IMPL(a_iac_first, pend == B_VERB, m_tvalid && m_tdata == CODE_IAC && !m_tlast,
                   "verb pending without iac on output")
  `TOR_ASSERT_IMPL(a_verb_second, pend == B_OPT,
                   m_tvalid && !m_tlast && m_tdata == cur.verb,
                   "option pending without verb on output")
  `TOR_ASSERT_IMPL(a_last_ends, m_tvalid && m_tlast, pend == B_NONE,
                   "reply still pending after last word")

endmodule
